// ===== design/ile_pkg.sv =====
// Package for the indexed list engine: sizes, codes, item types and the shift command.
`default_nettype none
package ile_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int COUNT_W  = 7;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_REM_FRONT = 3'd3,
        CMD_REM_BACK  = 3'd4,
        CMD_REM_AT    = 3'd5
    } ile_cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } ile_status_t;

    typedef struct packed {
        ile_cmd_t           cmd;
        logic [POS_W-1:0]   position;
        logic signed [31:0] data_in;
    } ile_in_t;

    typedef struct packed {
        logic signed [31:0] data_out;
        ile_status_t        status;
        logic [COUNT_W-1:0] count;
    } ile_out_t;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_INS  = 2'd1,
        OP_REM  = 2'd2
    } ile_op_t;

    // Broadcast to every cell of the row in each cycle.
    typedef struct packed {
        ile_op_t            op;
        logic [POS_W-1:0]   pos;
        logic [DATA_W-1:0]  value;
    } ile_shift_t;

endpackage
`default_nettype wire

// ===== design/ile_cell.sv =====
// One storage cell of the row: holds one value and shifts with its neighbours.
`default_nettype none
module ile_cell
    import ile_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [IDX_W-1:0]  idx,
    input  wire ile_shift_t        shift,
    input  wire logic [DATA_W-1:0] left_val,
    input  wire logic [DATA_W-1:0] right_val,
    output logic      [DATA_W-1:0] val,
    output logic      [DATA_W-1:0] tap
);

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;
    logic [POS_W-1:0]  my_pos;

    assign my_pos = POS_W'(idx);

    always_comb
    begin
        val_next = val_reg;
        case (shift.op)
            OP_INS:
            begin
                if (my_pos == shift.pos)
                begin
                    val_next = shift.value;
                end
                else if (my_pos > shift.pos)
                begin
                    val_next = left_val;
                end
            end
            OP_REM:
            begin
                if (my_pos >= shift.pos)
                begin
                    val_next = right_val;
                end
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
    // The addressed cell drives its value onto the shared read-out.
    assign tap = (my_pos == shift.pos) ? val_reg : '0;

endmodule
`default_nettype wire

// ===== design/ile_ctrl.sv =====
// Command decoder, occupancy counter and result register of the indexed list engine.
`default_nettype none
module ile_ctrl
    import ile_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire ile_in_t           item,
    input  wire logic [DATA_W-1:0] read_val,
    output ile_shift_t             shift,
    output ile_out_t               result,
    output logic                   done
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               done_reg;
    ile_out_t           result_reg;
    ile_out_t           result_next;
    ile_status_t        status;
    ile_op_t            op;
    logic [POS_W-1:0]   pos;
    logic               is_full;

    assign is_full = (count_reg == COUNT_W'(CAPACITY));

    always_comb
    begin
        status = ST_OK;
        op     = OP_HOLD;
        pos    = '0;
        case (item.cmd)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT:
            begin
                if (item.cmd == CMD_INS_FRONT)
                begin
                    pos = '0;
                end
                else if (item.cmd == CMD_INS_BACK)
                begin
                    pos = POS_W'(count_reg);
                end
                else
                begin
                    pos = item.position;
                end
                if (pos > POS_W'(count_reg))
                begin
                    status = ST_RANGE;
                end
                else if (is_full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    op = OP_INS;
                end
            end
            CMD_REM_FRONT, CMD_REM_BACK:
            begin
                pos = (item.cmd == CMD_REM_FRONT) ? '0 : POS_W'(count_reg - 1'b1);
                if (count_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    op = OP_REM;
                end
            end
            CMD_REM_AT:
            begin
                pos = item.position;
                if (pos >= POS_W'(count_reg))
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    op = OP_REM;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
        if (!accept)
        begin
            op = OP_HOLD;
        end
    end

    assign shift.op    = op;
    assign shift.pos   = pos;
    assign shift.value = item.data_in;

    always_comb
    begin
        count_next = count_reg;
        case (op)
            OP_INS:  count_next = count_reg + 1'b1;
            OP_REM:  count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
        result_next.data_out = (op == OP_REM) ? read_val : '0;
        result_next.status   = status;
        result_next.count    = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule
`default_nettype wire

// ===== design/indexed_list_engine.sv =====
// Top level of the indexed list engine: a row of shifting cells under one controller.
//
// The engine keeps an ordered sequence of up to CAPACITY signed 32-bit values,
// entry 0 being the front. Commands arrive on cmd_item and are taken at a rising
// clock edge at which start is high and busy is low. Each item inserts at the
// front, the back or a given position, or removes from the front, the back or a
// given position.
// Every item yields exactly one result on the result port, marked by done for a
// single cycle, in the cycle after the item is taken. The result carries the
// removed value (zero unless a removal succeeded), a status and the new count.
// A command that fails leaves the stored sequence untouched.
// The storage is a row of cells that all shift in the same cycle, so one item
// is taken every clock cycle; busy is never raised. This rate rests on the
// read-out of the addressed cell and the one-step shift of the row.
// Reset clears the count and the result strobe; the cells need no clearing
// because only entries below the count are ever read.
// The receiver cannot hold results off: each result must be taken in the
// cycle in which done is high.
`default_nettype none
module indexed_list_engine
    import ile_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire ile_in_t cmd_item,
    output ile_out_t     result,
    output logic         done
);

    logic              accept;
    ile_shift_t        shift;
    logic [DATA_W-1:0] cell_val [CAPACITY];
    logic [DATA_W-1:0] cell_tap [CAPACITY];
    logic [DATA_W-1:0] read_val;

    // Every item is finished at the clock edge that takes it, so the engine is always ready.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    ile_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (cmd_item),
        .read_val (read_val),
        .shift    (shift),
        .result   (result),
        .done     (done)
    );

    // The front cell never takes its left neighbour and the last cell's right
    // neighbour is past the end of the sequence, so both get harmless values.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_in;
        logic [DATA_W-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = shift.value;
        end
        else
        begin : g_mid_left
            assign left_in = cell_val[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_mid_right
            assign right_in = cell_val[i+1];
        end

        ile_cell u_cell
        (
            .clk       (clk),
            .idx       (IDX_W'(i)),
            .shift     (shift),
            .left_val  (left_in),
            .right_val (right_in),
            .val       (cell_val[i]),
            .tap       (cell_tap[i])
        );
    end

    // Only the addressed cell drives a non-zero tap, so an OR gives its value.
    always_comb
    begin
        read_val = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            read_val = read_val | cell_tap[k];
        end
    end

endmodule
`default_nettype wire

// ===== tb/indexed_list_engine_test.sv =====
// Testbench for the indexed list engine: directed table, biased random commands, shadow sequence.
module indexed_list_engine_test;
    import ile_pkg::*;

    // Command codes six and seven are not part of ile_cmd_t; the engine must ignore them.
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1250;
    localparam int IDLE_PCT     = 23;
    localparam int DRAIN_LIMIT  = 100;

    // One row of the directed table. Where typed is set, want holds the result
    // read straight off the behaviour; otherwise the shadow sequence decides it.
    // fill_first asks for the sequence to be filled to capacity before the row.
    typedef struct {
        ile_in_t  item;
        bit       typed;
        ile_out_t want;
        bit       fill_first;
    } stim_row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    ile_in_t  cmd_item;
    ile_out_t result;
    logic     done;

    // Travels alongside the item, so the result checker knows which rows carry
    // a hand-written expectation.
    bit       typed_known;
    ile_out_t typed_result;

    // Shadow copy of the stored sequence, entry 0 being the front.
    logic signed [31:0] stored_values[$];
    // Results still owed by the engine, oldest first.
    ile_out_t           pending_results[$];

    int        taken_count;
    int        error_count;
    int        status_seen[4];
    int        peak_fill;
    ile_out_t  predicted;
    ile_out_t  owed;
    stim_row_t directed_rows[23];

    indexed_list_engine uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd_item (cmd_item),
        .result   (result),
        .done     (done)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic ile_in_t make_item(ile_cmd_t c, int pos, logic [31:0] d);
        ile_in_t it;
        it.cmd      = c;
        it.position = POS_W'(pos);
        it.data_in  = d;
        return it;
    endfunction

    function automatic stim_row_t checked_row(ile_cmd_t c, int pos, logic [31:0] d);
        stim_row_t r;
        r.item       = make_item(c, pos, d);
        r.typed      = 1'b0;
        r.want       = '0;
        r.fill_first = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t typed_row(ile_cmd_t c, int pos, logic [31:0] d,
                                            logic [31:0] dout, ile_status_t st, int cnt);
        stim_row_t r;
        r = checked_row(c, pos, d);
        r.typed         = 1'b1;
        r.want.data_out = dout;
        r.want.status   = st;
        r.want.count    = COUNT_W'(cnt);
        return r;
    endfunction

    // Applies one command to the shadow sequence and returns the result the
    // engine owes for it. Range is checked before full for inserts, and a
    // failing command leaves the sequence alone.
    function automatic ile_out_t apply_command(ile_in_t it);
        ile_out_t r;
        int       n;
        int       p;
        bit       inserting;
        r.data_out = '0;
        r.status   = ST_OK;
        n          = stored_values.size();
        p          = it.position;
        inserting  = 1'b0;
        case (it.cmd)
            CMD_INS_FRONT:
            begin
                inserting = 1'b1;
                p         = 0;
            end
            CMD_INS_BACK:
            begin
                inserting = 1'b1;
                p         = n;
            end
            CMD_INS_AT:
            begin
                inserting = 1'b1;
            end
            CMD_REM_FRONT, CMD_REM_BACK:
            begin
                if (n == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    p          = (it.cmd == CMD_REM_FRONT) ? 0 : n - 1;
                    r.data_out = stored_values[p];
                    stored_values.delete(p);
                end
            end
            CMD_REM_AT:
            begin
                if (p >= n)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    r.data_out = stored_values[p];
                    stored_values.delete(p);
                end
            end
            default:
            begin
            end
        endcase
        if (inserting)
        begin
            if (p > n)
                r.status = ST_RANGE;
            else if (n >= CAPACITY)
                r.status = ST_FULL;
            else
                stored_values.insert(p, it.data_in);
        end
        r.count = COUNT_W'(stored_values.size());
        return r;
    endfunction

    // Draws one random command. bias is the percentage of inserts among the
    // real commands, so that phases push the sequence towards full or empty.
    // Positions are mostly legal for the current count, with the boundary and
    // the whole 7-bit range mixed in.
    function automatic ile_in_t random_item(int bias);
        ile_cmd_t    c;
        logic [31:0] d;
        int          n;
        int          lim;
        int          p;
        int          r;
        n = stored_values.size();
        if ($urandom_range(99) < 3)
        begin
            c = ile_cmd_t'($urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7);
        end
        else if ($urandom_range(99) < bias)
        begin
            case ($urandom_range(2))
                0:       c = CMD_INS_FRONT;
                1:       c = CMD_INS_BACK;
                default: c = CMD_INS_AT;
            endcase
        end
        else
        begin
            case ($urandom_range(2))
                0:       c = CMD_REM_FRONT;
                1:       c = CMD_REM_BACK;
                default: c = CMD_REM_AT;
            endcase
        end
        d = $urandom;
        if ($urandom_range(99) < 15)
        begin
            case ($urandom_range(3))
                0:       d = 32'h7FFF_FFFF;
                1:       d = 32'h8000_0000;
                2:       d = 32'h0000_0000;
                default: d = 32'hFFFF_FFFF;
            endcase
        end
        lim = (c <= CMD_INS_AT) ? n : ((n > 0) ? n - 1 : 0);
        r   = $urandom_range(99);
        if (r < 80)
            p = $urandom_range(lim);
        else if (r < 90)
            p = n;
        else
            p = $urandom_range(127);
        return make_item(c, p, d);
    endfunction

    // Presents one item from a falling edge and waits at falling edges until
    // the checker has seen it taken. Idle cycles, where allowed, come first.
    task automatic send_item(input ile_in_t it, input bit typed, input ile_out_t want,
                             input bit may_idle);
        int target;
        if (may_idle)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        target = taken_count + 1;
        start        <= 1'b1;
        cmd_item     <= it;
        typed_known  <= typed;
        typed_result <= want;
        do
            @(negedge clk);
        while (taken_count < target);
    endtask

    // Everything is sampled at the rising edge; inputs only move at the
    // falling edge. A taken item is predicted before any result in the same
    // edge is checked, which keeps the queue right whatever the latency.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predicted = apply_command(cmd_item);
                pending_results.push_back(typed_known ? typed_result : predicted);
                taken_count++;
                if (stored_values.size() > peak_fill)
                    peak_fill = stored_values.size();
            end
            if (done)
            begin
                status_seen[result.status]++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with nothing owed: data_out %0d status %0d count %0d",
                             $time, result.data_out, result.status, result.count);
                    error_count++;
                end
                else
                begin
                    owed = pending_results.pop_front();
                    if (result.data_out !== owed.data_out)
                    begin
                        $display("%0t: data_out expected %0d actual %0d",
                                 $time, owed.data_out, result.data_out);
                        error_count++;
                    end
                    if (result.status !== owed.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, owed.status, result.status);
                        error_count++;
                    end
                    if (result.count !== owed.count)
                    begin
                        $display("%0t: count expected %0d actual %0d",
                                 $time, owed.count, result.count);
                        error_count++;
                    end
                end
            end
        end
    end

    // Hard stop in case the engine hangs or stops answering.
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        ile_in_t it;
        int      random_items;
        int      bias;
        int      guard;

        rst_n        = 1'b0;
        start        = 1'b0;
        cmd_item     = '0;
        typed_known  = 1'b0;
        typed_result = '0;
        taken_count  = 0;
        error_count  = 0;
        peak_fill    = 0;
        for (int i = 0; i < 4; i++)
            status_seen[i] = 0;

        // Directed table. The opening rows work on an empty or nearly empty
        // sequence; the later rows run against a sequence filled to capacity.
        directed_rows[0]  = typed_row(CMD_REM_FRONT, 0, 32'h1234_5678, 0, ST_EMPTY, 0);
        directed_rows[1]  = typed_row(CMD_REM_BACK, 0, 0, 0, ST_EMPTY, 0);
        directed_rows[2]  = typed_row(CMD_REM_AT, 0, 0, 0, ST_RANGE, 0);
        directed_rows[3]  = typed_row(CMD_INS_AT, 127, 32'hFFFF_FFFF, 0, ST_RANGE, 0);
        directed_rows[4]  = typed_row(ile_cmd_t'(CMD_SPARE_6), 0, 32'hFFFF_FFFF, 0, ST_OK, 0);
        directed_rows[5]  = typed_row(CMD_INS_FRONT, 0, 32'h7FFF_FFFF, 0, ST_OK, 1);
        directed_rows[6]  = typed_row(CMD_INS_BACK, 0, 32'h8000_0000, 0, ST_OK, 2);
        directed_rows[7]  = typed_row(CMD_INS_AT, 1, 32'hFFFF_FFFF, 0, ST_OK, 3);
        // Inserting at the position equal to the count appends at the back.
        directed_rows[8]  = typed_row(CMD_INS_AT, 3, 32'h0000_0000, 0, ST_OK, 4);
        // Removing at the last index takes the back entry.
        directed_rows[9]  = typed_row(CMD_REM_AT, 3, 0, 0, ST_OK, 3);
        directed_rows[10] = typed_row(CMD_REM_AT, 127, 0, 0, ST_RANGE, 3);
        directed_rows[11] = checked_row(CMD_REM_AT, 1, 32'h5555_5555);
        directed_rows[12] = typed_row(ile_cmd_t'(CMD_SPARE_7), 127, 32'h5A5A_5A5A, 0, ST_OK, 2);
        directed_rows[13] = typed_row(CMD_REM_FRONT, 0, 0, 32'h7FFF_FFFF, ST_OK, 1);
        directed_rows[14] = typed_row(CMD_REM_BACK, 0, 0, 32'h8000_0000, ST_OK, 0);
        directed_rows[15] = typed_row(CMD_INS_FRONT, 0, 32'h0000_0001, 0, ST_FULL, CAPACITY);
        directed_rows[15].fill_first = 1'b1;
        directed_rows[16] = typed_row(CMD_INS_BACK, 0, 32'h0000_0002, 0, ST_FULL, CAPACITY);
        directed_rows[17] = typed_row(CMD_INS_AT, CAPACITY, 32'h3, 0, ST_FULL, CAPACITY);
        // The range check wins over the full check.
        directed_rows[18] = typed_row(CMD_INS_AT, CAPACITY + 1, 32'h4, 0, ST_RANGE, CAPACITY);
        directed_rows[19] = typed_row(CMD_REM_AT, CAPACITY, 0, 0, ST_RANGE, CAPACITY);
        directed_rows[20] = checked_row(CMD_REM_AT, CAPACITY - 1, 0);
        directed_rows[21] = checked_row(CMD_INS_AT, CAPACITY - 1, 32'hCAFE_F00D);
        directed_rows[22] = checked_row(CMD_REM_AT, 0, 0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].fill_first)
            begin
                while (stored_values.size() < CAPACITY)
                    send_item(make_item(CMD_INS_BACK, 0, $urandom), 1'b0, '0, 1'b1);
            end
            send_item(directed_rows[i].item, directed_rows[i].typed,
                      directed_rows[i].want, 1'b1);
        end

        // Random part. The insert share swings between phases so the
        // sequence keeps travelling between empty and full. A long stretch in
        // the middle runs back to back with no idle cycles.
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case ((random_items / 120) % 3)
                0:       bias = 80;
                1:       bias = 20;
                default: bias = 50;
            endcase
            it = random_item(bias);
            send_item(it, 1'b0, '0, !(random_items >= 400 && random_items < 650));
            if (it.cmd <= CMD_REM_AT)
                random_items++;
        end

        start <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (4) @(negedge clk);

        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            error_count++;
        end

        $display("Run took %0d items; the sequence peaked at %0d of %0d entries.",
                 taken_count, peak_fill, CAPACITY);
        $display("Statuses seen: ok %0d, empty %0d, out of range %0d, full %0d.",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_RANGE],
                 status_seen[ST_FULL]);
        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
